// ===== rtl/sjf_pkg.sv =====
// ---------------------------------------------------------------------------
// Shortest-job-first scheduler package
// Shared field widths, item structs and the command and status groups
// that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package sjf_pkg;

  // Default sizing of the job store and of the time fields.
  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed widths of the channel fields.
  localparam int BURST_W = 16;
  localparam int ARR_W   = 16;
  localparam int JOB_W   = 4;
  localparam int RES_W   = 21;

  // One job as it is loaded.
  typedef struct packed {
    logic [BURST_W-1:0] burst_length;
    logic [ARR_W-1:0]   arrival_time;
    logic               final_job;
  } in_item_t;

  // One scheduled job as it is reported.
  typedef struct packed {
    logic [JOB_W-1:0] job_index;
    logic [RES_W-1:0] turnaround;
    logic [RES_W-1:0] waiting;
    logic             end_of_schedule;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;     // store the accepted job
    logic scan_start;  // restart the scan of the job store
    logic rd_en;       // read the next stored job
    logic pick;        // commit the chosen job and advance time
    logic form;        // build the result item
    logic finish;      // drop the job set after its last result
  } sjf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;   // the read issued now is the last stored job
    logic all_done;    // every stored job has been scheduled
  } sjf_sts_t;

endpackage

// ===== rtl/sjf_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module sjf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/sjf_ctrl.sv =====
// ---------------------------------------------------------------------------
// Shortest-job-first scheduler controller
// Sequences loading, the store scan, the pick and the result handshake.
// ---------------------------------------------------------------------------
module sjf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_final,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output sjf_pkg::sjf_cmd_t cmd,
  input  sjf_pkg::sjf_sts_t sts
);
  import sjf_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PICK  = 3'd3;
  localparam logic [2:0] ST_FORM  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        cmd.load_en = in_acc;
        if (in_acc && in_final) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_PICK;
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_FORM;
      end
      ST_FORM: begin
        cmd.form  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (sts.all_done) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_LOAD;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sjf_dpath.sv =====
// ---------------------------------------------------------------------------
// Shortest-job-first scheduler datapath
// Job store, scan compare, schedule clock and the result register.
// ---------------------------------------------------------------------------
module sjf_dpath #(
  parameter int MAX_JOBS  = sjf_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = sjf_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sjf_pkg::sjf_cmd_t  cmd,
  output sjf_pkg::sjf_sts_t  sts,
  input  sjf_pkg::in_item_t  in_item,
  output sjf_pkg::out_item_t out_item
);
  import sjf_pkg::*;

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int CT_W  = TIME_BITS + $clog2(MAX_JOBS) + 1;
  localparam int IN_W  = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;
  localparam int OUT_W = (CT_W > RES_W) ? CT_W : RES_W;
  localparam int JO_W  = (IDX_W > JOB_W) ? IDX_W : JOB_W;

  // Control registers.
  logic [CNT_W-1:0]    count_r,   count_nxt;
  logic [CNT_W-1:0]    sched_r,   sched_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [MAX_JOBS-1:0] done_r,    done_nxt;
  logic [CT_W-1:0]     time_r,    time_nxt;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                af_r,      af_nxt;
  logic                lf_r,      lf_nxt;

  // Best-candidate payload registers.
  logic [TIME_BITS-1:0] ab_r, aa_r, lb_r, la_r;
  logic [IDX_W-1:0]     ai_r, li_r;

  // Chosen-job payload registers.
  logic [CT_W-1:0]      wait_r;
  logic [TIME_BITS-1:0] burst_r;
  logic [IDX_W-1:0]     idx_r;
  out_item_t            out_r;

  // Store interface.
  logic [IN_W-1:0]        ld_burst_ext, ld_arr_ext;
  logic                   wr_en;
  logic [2*TIME_BITS-1:0] wr_data, rd_data;
  logic [TIME_BITS-1:0]   q_burst, q_arr;

  // Scan compare and pick signals.
  logic                 pending, arrived, upd_a, upd_l;
  logic [CT_W-1:0]      start_t, wait_nxt;
  logic [TIME_BITS-1:0] sel_arr, sel_burst;
  logic [IDX_W-1:0]     sel_idx;
  logic [OUT_W-1:0]     tat_w, wait_w;
  logic [JO_W-1:0]      job_w;

  // Inputs are taken modulo the time width.
  assign ld_burst_ext = IN_W'(in_item.burst_length);
  assign ld_arr_ext   = IN_W'(in_item.arrival_time);
  assign wr_data      = {ld_arr_ext[TIME_BITS-1:0], ld_burst_ext[TIME_BITS-1:0]};
  assign wr_en        = cmd.load_en && (count_r < CNT_W'(MAX_JOBS));

  sjf_ram #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (MAX_JOBS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_data),
    .raddr (scan_idx_r),
    .rdata (rd_data)
  );

  assign q_burst = rd_data[TIME_BITS-1:0];
  assign q_arr   = rd_data[2*TIME_BITS-1:TIME_BITS];

  // Compare the job read back against both running candidates: the shortest
  // arrived job, and the earliest arrival (shortest burst among equals).
  assign pending = rd_vld_r && !done_r[rd_idx_r];
  assign arrived = CT_W'(q_arr) <= time_r;
  assign upd_a   = pending && arrived && (!af_r || (q_burst < ab_r));
  assign upd_l   = pending && (!lf_r || (q_arr < la_r) ||
                               ((q_arr == la_r) && (q_burst < lb_r)));

  // With no arrived job, time jumps to the earliest pending arrival.
  always_comb begin
    if (af_r) begin
      start_t   = time_r;
      sel_arr   = aa_r;
      sel_burst = ab_r;
      sel_idx   = ai_r;
    end else begin
      start_t   = CT_W'(la_r);
      sel_arr   = la_r;
      sel_burst = lb_r;
      sel_idx   = li_r;
    end
  end
  assign wait_nxt = start_t - CT_W'(sel_arr);

  // Next values of the control registers.
  always_comb begin
    count_nxt    = count_r;
    sched_nxt    = sched_r;
    scan_idx_nxt = scan_idx_r;
    done_nxt     = done_r;
    time_nxt     = time_r;
    af_nxt       = af_r || upd_a;
    lf_nxt       = lf_r || upd_l;
    if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.scan_start) begin
      scan_idx_nxt = '0;
      af_nxt       = 1'b0;
      lf_nxt       = 1'b0;
    end else if (cmd.rd_en) begin
      scan_idx_nxt = scan_idx_r + IDX_W'(1);
    end
    if (cmd.pick) begin
      done_nxt[sel_idx] = 1'b1;
      time_nxt          = start_t + CT_W'(sel_burst);
      sched_nxt         = sched_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      count_nxt = '0;
      sched_nxt = '0;
      done_nxt  = '0;
      time_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sched_r    <= '0;
      scan_idx_r <= '0;
      done_r     <= '0;
      time_r     <= '0;
      rd_vld_r   <= 1'b0;
      af_r       <= 1'b0;
      lf_r       <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      sched_r    <= sched_nxt;
      scan_idx_r <= scan_idx_nxt;
      done_r     <= done_nxt;
      time_r     <= time_nxt;
      rd_vld_r   <= cmd.rd_en;
      af_r       <= af_nxt;
      lf_r       <= lf_nxt;
    end
  end

  // Candidate payloads follow the compare results.
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    if (upd_a) begin
      ab_r <= q_burst;
      aa_r <= q_arr;
      ai_r <= rd_idx_r;
    end
    if (upd_l) begin
      lb_r <= q_burst;
      la_r <= q_arr;
      li_r <= rd_idx_r;
    end
    if (cmd.pick) begin
      wait_r  <= wait_nxt;
      burst_r <= sel_burst;
      idx_r   <= sel_idx;
    end
    if (cmd.form) begin
      out_r <= {job_w[JOB_W-1:0], tat_w[RES_W-1:0], wait_w[RES_W-1:0], sts.all_done};
    end
  end

  // Turnaround is the wait plus the burst; results are reported modulo 2^21.
  assign tat_w  = OUT_W'(wait_r) + OUT_W'(burst_r);
  assign wait_w = OUT_W'(wait_r);
  assign job_w  = JO_W'(idx_r);

  assign sts.scan_last = (CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r;
  assign sts.all_done  = (sched_r == count_r);
  assign out_item      = out_r;

endmodule

// ===== rtl/shortest_job_first_scheduler_core.sv =====
// ---------------------------------------------------------------------------
// Non-preemptive shortest-job-first scheduler
// Loads a job set, then reports the jobs in run order with their times.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel takes one job item per cycle (burst length, arrival
//   time, final flag) while in_stall is low. Jobs beyond MAX_JOBS are
//   dropped. The item with final_job set ends loading; in_stall then stays
//   high until the last result of the set has been taken.
//   The result channel gives one item per job in run order: job index,
//   turnaround, waiting time, and end_of_schedule on the last one.
//   For each result the controller reads every job from the store through
//   its single read port, then drains the read, picks the job and advances
//   time, forms the result and offers it.
//   While out_stall is high the result holds and the scheduler waits.
//   After the last result the block returns to loading with an empty set.
//   Reset (rst_n low, synchronous) empties the job set and enters loading;
//   the job store itself is not cleared.
// ---------------------------------------------------------------------------
module shortest_job_first_scheduler_core #(
  parameter int MAX_JOBS  = sjf_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = sjf_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sjf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sjf_pkg::out_item_t out_item
);
  import sjf_pkg::*;

  sjf_cmd_t cmd;
  sjf_sts_t sts;

  // Sequencing.
  sjf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_item.final_job),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Store, scan and timing.
  sjf_dpath #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ===== rtl/sjf_checker.sv =====
// ---------------------------------------------------------------------------
// Shortest-job-first scheduler port checker
// Checks the port behavior of the scheduler over time.
// ---------------------------------------------------------------------------
module sjf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input sjf_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input sjf_pkg::out_item_t out_item
);
  import sjf_pkg::*;

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // No job is loaded while a result is on offer.
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is shown");

  // The final job closes loading.
  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.final_job |=> in_stall && !out_valid)
    else $error("loading did not close after the final job");

  // After the last result the block loads again; otherwise it keeps scheduling.
  a_end_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> (in_stall != out_item.end_of_schedule ||
                                 $past(out_item.end_of_schedule) == !in_stall))
    else $error("loading state wrong after a result item");

endmodule

bind shortest_job_first_scheduler_core sjf_checker u_sjf_checker (.*);
